### sv/fta_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frame time averager.
// No dependencies; imported by every other file of the block.
package fta_pkg;

   localparam int unsigned TS_W      = 32;
   localparam int unsigned RATE_W    = 16;
   localparam int unsigned ACC_W     = 33;
   localparam logic [TS_W-1:0]   TPS_RESET = 32'd1000;
   localparam logic [RATE_W-1:0] RATE_MAX  = 16'hFFFF;

   // Sequencer states of the top level.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_TEST,
      ST_SUB,
      ST_ADD,
      ST_RATE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } fta_state_type;

   // Divider status back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### sv/fta_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fta_pkg for the status struct.
module fta_divider #(
   parameter int unsigned SUM_W = 38,
   parameter int unsigned CNT_W = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SUM_W-1:0]         dividend,
   input  logic [CNT_W-1:0]         divisor,
   output fta_pkg::div_status_type  status,
   output logic [fta_pkg::TS_W-1:0] quotient
);
   import fta_pkg::*;

   localparam int unsigned ITER_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    shifted;
   logic              fits;

   // one step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, dvd_ff[SUM_W-1]};
      fits    = (shifted >= {1'b0, dsr_ff});
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         iter_in = ITER_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[SUM_W-2:0], fits};
         rem_in  = fits ? CNT_W'(shifted - {1'b0, dsr_ff}) : shifted[CNT_W-1:0];
         iter_in = iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   // quotient never exceeds the largest delta, so the low word is exact
   assign quotient    = dvd_ff[TS_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### sv/frame_time_averager_top.sv
`timescale 1ns / 1ps
// Frame time averager: top level with sequencer, delta window memory and rate counter.
// Depends on fta_pkg and fta_divider.
//
// Usage:
//   req_ channel: one beat per frame, carrying the free-running tick counter
//     value (req_timestamp). The block takes the wrapped delta from the last
//     timestamp, drops it as an outlier if it is a second or more away from
//     the running average, and otherwise stores it in a circular window of
//     the last WINDOW_DEPTH deltas.
//   rsp_ channel: one beat per request: truncated mean of the held deltas,
//     frames counted in the last completed second, and number held.
//   csr_ channel: writes ticks_per_second; always ready. Write only when idle.
// Sequence: six sequencer steps, then the divider (one quotient bit per
//   cycle, 32 + log2(WINDOW_DEPTH) steps), then the output load; an empty
//   window skips the divider and gives a zero average.
// Flow: one request at a time, req_ready high only in idle; a new request
//   is taken only after the last one has loaded its result.
// Reset: synchronous, clears all counters, the average and the baseline
//   timestamp to zero and ticks_per_second to 1000. The window memory is not
//   cleared; an entry is only read after it has been written.
// Stall: the result sits in an output register. The next request is taken
//   while it waits; that request's result holds in the final step until the
//   receiver takes the earlier beat.
module frame_time_averager_top #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [fta_pkg::TS_W-1:0]              req_timestamp,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [fta_pkg::TS_W-1:0]              rsp_average_frame_ticks,
   output logic [fta_pkg::RATE_W-1:0]            rsp_frame_rate,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]     rsp_samples_held,
   // configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fta_pkg::TS_W-1:0]              csr_ticks_per_second
);
   import fta_pkg::*;

   localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   // worst case sum: WINDOW_DEPTH deltas of 2^32-1
   localparam int unsigned SUM_W = TS_W + $clog2(WINDOW_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(WINDOW_DEPTH - 1);

   fta_state_type state_ff, state_in;

   // architectural state
   logic [TS_W-1:0]   tps_ff;
   logic [TS_W-1:0]   prev_ff;
   logic [PTR_W-1:0]  wp_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [TS_W-1:0]   avg_ff;
   logic [RATE_W-1:0] frames_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [RATE_W-1:0] rate_ff;

   // per-request working registers
   logic [TS_W-1:0]   ts_ff;
   logic [TS_W-1:0]   delta_ff;
   logic              take_ff;
   logic [TS_W-1:0]   old_ff;

   // delta window
   logic [TS_W-1:0]   window_mem [WINDOW_DEPTH];

   // output register
   logic              rsp_valid_ff;
   logic [TS_W-1:0]   rsp_avg_ff;
   logic [RATE_W-1:0] rsp_rate_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   // sequencer outputs
   logic req_take, div_start, rsp_load, window_full;
   div_status_type  div_status;
   logic [TS_W-1:0] div_quotient;

   // combinational helpers
   logic [TS_W-1:0]   abs_diff;
   logic [ACC_W-1:0]  acc_sum;
   logic [RATE_W-1:0] frames_inc;

   assign window_full = (count_ff == DEPTH_CNT);
   assign csr_ready   = 1'b1;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DELTA;
         ST_DELTA:    state_in = ST_TEST;
         ST_TEST:     state_in = ST_SUB;
         ST_SUB:      state_in = ST_ADD;
         ST_ADD:      state_in = ST_RATE;
         ST_RATE:     state_in = ST_DIV_GO;
         // an empty window skips the divide: average is zero
         ST_DIV_GO:   state_in = (count_ff == '0) ? ST_DONE : ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_status.done) state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_DIV_GO: div_start = (count_ff != '0);
         ST_DONE:   rsp_load  = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- datapath ----------------
   // outlier distance from the average before this frame
   assign abs_diff   = (delta_ff >= avg_ff) ? (delta_ff - avg_ff) : (avg_ff - delta_ff);
   assign acc_sum    = acc_ff + ACC_W'(delta_ff);
   assign frames_inc = (frames_ff == RATE_MAX) ? frames_ff : frames_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff    <= TPS_RESET;
         prev_ff   <= '0;
         wp_ff     <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         avg_ff    <= '0;
         frames_ff <= '0;
         acc_ff    <= '0;
         rate_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            tps_ff <= csr_ticks_per_second;
         end
         case (state_ff)
            ST_DELTA: prev_ff <= ts_ff;
            // full window: retire the oldest delta first
            ST_SUB: if (take_ff && window_full) sum_ff <= sum_ff - SUM_W'(old_ff);
            ST_ADD: begin
               if (take_ff) begin
                  sum_ff <= sum_ff + SUM_W'(delta_ff);
                  wp_ff  <= (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
                  if (!window_full) count_ff <= count_ff + 1'b1;
               end
            end
            ST_RATE: begin
               // latched count includes this frame
               if (acc_sum > ACC_W'(tps_ff)) begin
                  rate_ff   <= frames_inc;
                  frames_ff <= '0;
                  acc_ff    <= '0;
               end else begin
                  frames_ff <= frames_inc;
                  acc_ff    <= acc_sum;
               end
            end
            ST_DIV_GO:   if (count_ff == '0) avg_ff <= '0;
            ST_DIV_WAIT: if (div_status.done) avg_ff <= div_quotient;
            default: ;
         endcase
      end
   end

   // per-request payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         ts_ff <= req_timestamp;
      end
      if (state_ff == ST_DELTA) begin
         delta_ff <= ts_ff - prev_ff;
      end
      if (state_ff == ST_TEST) begin
         take_ff <= (abs_diff < tps_ff);
      end
   end

   // window memory: one write port, one registered read at the write pointer
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADD && take_ff) begin
         window_mem[wp_ff] <= delta_ff;
      end
      old_ff <= window_mem[wp_ff];
   end

   fta_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_avg_ff  <= avg_ff;
         rsp_rate_ff <= rate_ff;
         rsp_cnt_ff  <= count_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_average_frame_ticks = rsp_avg_ff;
   assign rsp_frame_rate          = rsp_rate_ff;
   assign rsp_samples_held        = rsp_cnt_ff;

endmodule

### sv/fta_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the frame time averager, bound to the top level.
// Depends on fta_pkg and frame_time_averager_top.
module fta_checker #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fta_pkg::TS_W-1:0]          rsp_average_frame_ticks,
   input logic [fta_pkg::RATE_W-1:0]        rsp_frame_rate,
   input logic [$clog2(WINDOW_DEPTH+1)-1:0] rsp_samples_held
);
   import fta_pkg::*;

   localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_frame_ticks)
         && $stable(rsp_frame_rate) && $stable(rsp_samples_held))
      else $error("result beat changed while stalled");

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // empty window gives a zero average, and the count stays within the depth
   a_empty_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_samples_held <= CNT_W'(WINDOW_DEPTH))
         && ((rsp_samples_held != '0) || (rsp_average_frame_ticks == '0)))
      else $error("bad average or sample count");

endmodule

bind frame_time_averager_top fta_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_fta_checker (.*);
